// ----- design/table_driven_lexer_top_defines.svh -----
// -----------------------------------------------------------------------------
// table_driven_lexer_top_defines.svh
// Assertion macros shared by the lexer checker.
// -----------------------------------------------------------------------------
`ifndef TABLE_DRIVEN_LEXER_TOP_DEFINES_SVH
`define TABLE_DRIVEN_LEXER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define TDL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TDL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/tdl_pkg.sv -----
// -----------------------------------------------------------------------------
// tdl_pkg
// Token types and fixed constants of the table driven lexer.
// -----------------------------------------------------------------------------
package tdl_pkg;

	localparam int SHORT_NAME_MAX = 7;
	localparam int TOK_LEN_W      = 16;
	localparam int OUTQ_DEPTH     = 4;
	localparam int OUTQ_PTR_W     = $clog2(OUTQ_DEPTH);

	typedef enum logic [4:0] {
		KIND_LBRACE   = 5'd0,
		KIND_RBRACE   = 5'd1,
		KIND_LPAREN   = 5'd2,
		KIND_RPAREN   = 5'd3,
		KIND_LBRACKET = 5'd4,
		KIND_RBRACKET = 5'd5,
		KIND_COLON    = 5'd6,
		KIND_SEMI     = 5'd7,
		KIND_COMMA    = 5'd8,
		KIND_BAR      = 5'd9,
		KIND_INT      = 5'd10,
		KIND_OP       = 5'd11,
		KIND_IDENT    = 5'd12,
		KIND_EQ       = 5'd13,
		KIND_LET      = 5'd14,
		KIND_EOF      = 5'd15,
		KIND_ERR      = 5'd16
	} kind_t;

	// Packed short names of the keywords
	localparam logic [63:0] KEY_BAR = 64'h0000_0000_0000_017C;
	localparam logic [63:0] KEY_EQ  = 64'h0000_0000_0000_013D;
	localparam logic [63:0] KEY_LET = 64'h0000_0000_016C_6574;

	typedef struct packed {
		kind_t                  kind;
		logic [2:0]             prec;
		logic [63:0]            value;
		logic [TOK_LEN_W-1:0]   length;
		logic                   hashed;
		logic                   last;
	} tok_t;

	// Tokens produced by one byte, in order; cnt is 0, 1 or 2
	typedef struct packed {
		logic [1:0] cnt;
		tok_t       tok0;
		tok_t       tok1;
	} push_t;

endpackage

// ----- design/tdl_tok_fifo.sv -----
// -----------------------------------------------------------------------------
// tdl_tok_fifo
// Small token queue: takes up to two tokens a cycle, hands out one.
// -----------------------------------------------------------------------------
module tdl_tok_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  tdl_pkg::push_t push,
	output logic          room,
	output logic          out_valid,
	input  logic          out_ready,
	output tdl_pkg::tok_t head
);

	localparam int CNT_W = tdl_pkg::OUTQ_PTR_W + 1;

	tdl_pkg::tok_t                   mem_q [tdl_pkg::OUTQ_DEPTH];
	logic [tdl_pkg::OUTQ_PTR_W-1:0] wr_q;
	logic [tdl_pkg::OUTQ_PTR_W-1:0] rd_q;
	logic [CNT_W-1:0]                count_q;
	logic                            pop;
	logic [tdl_pkg::OUTQ_PTR_W-1:0] wr_next1;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign room      = (count_q <= CNT_W'(tdl_pkg::OUTQ_DEPTH - 2));
	assign head      = mem_q[rd_q];
	assign wr_next1  = wr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.tok0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_next1] <= push.tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + tdl_pkg::OUTQ_PTR_W'(push.cnt);
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push.cnt) - CNT_W'(pop);
		end
	end

endmodule

// ----- design/tdl_scan.sv -----
// -----------------------------------------------------------------------------
// tdl_scan
// Character classification, token state and token build for one byte.
// -----------------------------------------------------------------------------
module tdl_scan #(
	parameter int LENGTH_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  logic [7:0]     char_byte,
	input  logic           newline_comma_ok,
	output tdl_pkg::push_t push
);

	localparam int CNT_W = (LENGTH_BITS > 16) ? 16 : LENGTH_BITS;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_NAME,
		MODE_OPRUN,
		MODE_NUM
	} mode_t;

	mode_t             mode_q;
	logic [63:0]       packed_q;
	logic [31:0]       hash_q;
	logic [CNT_W-1:0]  count_q;
	logic [31:0]       num_q;
	logic [2:0]        prec_q;

	logic              is_digit;
	logic              is_letter;
	logic              is_begin;
	logic              is_inner;
	logic              op_hit;
	logic [2:0]        op_lvl;
	logic              punct_hit;
	tdl_pkg::kind_t    punct_kind;
	logic              cont;
	logic              has_a;
	logic              has_b;
	tdl_pkg::tok_t     tok_a;
	tdl_pkg::tok_t     tok_b;
	logic [31:0]       hash_sq;
	logic [31:0]       hash_fin;
	logic [63:0]       ext_packed;
	logic [31:0]       ext_hash;

	// Character class table
	always_comb begin
		is_digit  = (char_byte inside {[8'h30:8'h39]});
		is_letter = (char_byte inside {[8'h61:8'h7A], [8'h41:8'h5A]});
		is_begin  = is_letter || (char_byte == 8'h27) || (char_byte == 8'h2E);
		is_inner  = is_letter || is_digit || char_byte[7];
		op_hit    = 1'b1;
		op_lvl    = 3'd0;
		case (char_byte)
			8'h3D, 8'h7C:        op_lvl = 3'd0;
			8'h26:               op_lvl = 3'd1;
			8'h3C, 8'h3E:        op_lvl = 3'd2;
			8'h2B, 8'h2D:        op_lvl = 3'd3;
			8'h2A, 8'h2F, 8'h5C: op_lvl = 3'd4;
			default:             op_hit = 1'b0;
		endcase
		punct_hit  = 1'b1;
		punct_kind = tdl_pkg::KIND_ERR;
		case (char_byte)
			8'h7B:   punct_kind = tdl_pkg::KIND_LBRACE;
			8'h7D:   punct_kind = tdl_pkg::KIND_RBRACE;
			8'h28:   punct_kind = tdl_pkg::KIND_LPAREN;
			8'h29:   punct_kind = tdl_pkg::KIND_RPAREN;
			8'h5B:   punct_kind = tdl_pkg::KIND_LBRACKET;
			8'h5D:   punct_kind = tdl_pkg::KIND_RBRACKET;
			8'h3A:   punct_kind = tdl_pkg::KIND_COLON;
			8'h3B:   punct_kind = tdl_pkg::KIND_SEMI;
			8'h2C:   punct_kind = tdl_pkg::KIND_COMMA;
			default: punct_hit  = 1'b0;
		endcase
	end

	assign cont = ((mode_q == MODE_NAME) && is_inner) ||
	              ((mode_q == MODE_OPRUN) && op_hit) ||
	              ((mode_q == MODE_NUM) && is_digit);

	assign ext_packed = {packed_q[55:0], char_byte};
	assign ext_hash   = {hash_q[14:0], hash_q[31:15]} + ext_packed[31:0];
	assign hash_sq    = hash_q * {hash_q[30:0], 1'b1};
	assign hash_fin   = (hash_sq == '0) ? 32'd1 : hash_sq;

	// Closing token of the open run
	always_comb begin
		has_a        = (mode_q != MODE_IDLE) && !cont;
		tok_a        = '0;
		tok_a.kind   = tdl_pkg::KIND_INT;
		if (mode_q == MODE_NUM) begin
			tok_a.value = {32'd0, num_q};
		end else begin
			tok_a.kind   = (mode_q == MODE_OPRUN) ? tdl_pkg::KIND_OP : tdl_pkg::KIND_IDENT;
			tok_a.prec   = (mode_q == MODE_OPRUN) ? prec_q : 3'd0;
			tok_a.length = tdl_pkg::TOK_LEN_W'(count_q);
			if (count_q <= CNT_W'(tdl_pkg::SHORT_NAME_MAX)) begin
				tok_a.value = packed_q;
				if (packed_q == tdl_pkg::KEY_BAR) begin
					tok_a.kind = tdl_pkg::KIND_BAR;
					tok_a.prec = 3'd0;
				end else if (packed_q == tdl_pkg::KEY_EQ) begin
					tok_a.kind = tdl_pkg::KIND_EQ;
					tok_a.prec = 3'd0;
				end else if (packed_q == tdl_pkg::KEY_LET) begin
					tok_a.kind = tdl_pkg::KIND_LET;
					tok_a.prec = 3'd0;
				end
			end else begin
				tok_a.value  = {32'd0, hash_fin};
				tok_a.hashed = 1'b1;
			end
		end
	end

	// Single-byte token of a fresh start
	always_comb begin
		has_b      = 1'b0;
		tok_b      = '0;
		tok_b.kind = tdl_pkg::KIND_ERR;
		if (!cont && !op_hit && !is_begin && !is_digit) begin
			if (punct_hit) begin
				has_b      = 1'b1;
				tok_b.kind = punct_kind;
			end else if (char_byte == 8'h00) begin
				has_b      = 1'b1;
				tok_b.kind = tdl_pkg::KIND_EOF;
			end else if (char_byte == 8'h20) begin
				has_b = 1'b0;
			end else if (char_byte == 8'h0D || char_byte == 8'h0A) begin
				has_b      = newline_comma_ok;
				tok_b.kind = tdl_pkg::KIND_COMMA;
			end else begin
				has_b = 1'b1;
			end
		end
	end

	// Order the tokens and mark the final one
	always_comb begin
		push      = '0;
		push.tok0 = has_a ? tok_a : tok_b;
		push.tok1 = tok_b;
		if (go) begin
			push.cnt = 2'(has_a) + 2'(has_b);
		end
		if (has_a && has_b) begin
			push.tok1.last = 1'b1;
		end else begin
			push.tok0.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			packed_q <= '0;
			hash_q   <= '0;
			count_q  <= '0;
			num_q    <= '0;
			prec_q   <= '0;
		end else if (go) begin
			if (cont) begin
				if (mode_q == MODE_NUM) begin
					num_q <= (num_q << 3) + (num_q << 1) + {28'd0, char_byte[3:0]};
				end else begin
					packed_q <= ext_packed;
					hash_q   <= ext_hash;
					if (count_q != '1) begin
						count_q <= count_q + 1'b1;
					end
				end
			end else if (op_hit || is_begin) begin
				packed_q <= {55'd0, 1'b1, char_byte};
				hash_q   <= {23'd0, 1'b1, char_byte};
				count_q  <= CNT_W'(1);
				prec_q   <= op_hit ? op_lvl : 3'd0;
				mode_q   <= op_hit ? MODE_OPRUN : MODE_NAME;
			end else if (is_digit) begin
				num_q  <= {28'd0, char_byte[3:0]};
				mode_q <= MODE_NUM;
			end else begin
				mode_q <= MODE_IDLE;
			end
		end
	end

endmodule

// ----- design/table_driven_lexer_top.sv -----
// -----------------------------------------------------------------------------
// table_driven_lexer_top
// Streaming lexer: one source byte in, zero to two tokens out.
// -----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one source byte (char_byte) and the
// newline_comma_ok flag per request. Output channel out_valid/out_ready
// carries one token per request; last_of_run marks the final token of a byte.
// A byte sits in an input register until the queue has room, is classified
// and scanned there, and its tokens land in a four-entry token queue. A token
// is offered once its byte has left the input register and been written into
// the queue. A byte that closes a run with a single-byte token produces two.
// Throughput is one byte per cycle while the queue keeps room for two tokens;
// the queue drains one token per cycle, so bytes that yield two tokens back
// up input when they follow each other.
// Reset clears the scan state to idle with no token open and empties the
// queue. When the receiver stalls, the queue fills and in_ready drops; no
// token is lost or repeated.
// -----------------------------------------------------------------------------
module table_driven_lexer_top #(
	parameter int LENGTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	input  logic        newline_comma_ok,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  token_kind,
	output logic [2:0]  token_level,
	output logic [63:0] token_value,
	output logic [15:0] token_length,
	output logic        is_hashed,
	output logic        last_of_run
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           ok_s1;
	logic           room;
	logic           go;
	tdl_pkg::push_t push;
	tdl_pkg::tok_t  head;

	assign go       = valid_s1 && room;
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= char_byte;
			ok_s1   <= newline_comma_ok;
		end
	end

	tdl_scan #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_scan (
		.clk             (clk),
		.arst_n          (arst_n),
		.go              (go),
		.char_byte       (byte_s1),
		.newline_comma_ok(ok_s1),
		.push            (push)
	);

	tdl_tok_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head     (head)
	);

	assign token_kind   = head.kind;
	assign token_level  = head.prec;
	assign token_value  = head.value;
	assign token_length = head.length;
	assign is_hashed    = head.hashed;
	assign last_of_run  = head.last;

endmodule

// ----- design/tdl_checker.sv -----
// -----------------------------------------------------------------------------
// tdl_checker
// Port-level checks of the lexer token stream, bound to the top level.
// -----------------------------------------------------------------------------
`include "table_driven_lexer_top_defines.svh"

module tdl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [4:0]  token_kind,
	input logic [2:0]  token_level,
	input logic [63:0] token_value,
	input logic [15:0] token_length,
	input logic        is_hashed
);

	`TDL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(token_value), "token changed while stalled")

	`TDL_ASSERT_NOW(a_prec_op_only, out_valid && token_kind != tdl_pkg::KIND_OP, token_level == 3'd0, "precedence on a non-operator token")

	`TDL_ASSERT_NOW(a_hash_long_name, out_valid && is_hashed, token_length > 16'd7 && (token_kind == tdl_pkg::KIND_OP || token_kind == tdl_pkg::KIND_IDENT), "hash on a short or non-name token")

	`TDL_ASSERT_NOW(a_no_len_plain, out_valid && (token_kind <= tdl_pkg::KIND_COMMA || token_kind == tdl_pkg::KIND_INT || token_kind == tdl_pkg::KIND_EOF || token_kind == tdl_pkg::KIND_ERR), token_length == 16'd0 && !is_hashed, "length on a non-name token")

endmodule

bind table_driven_lexer_top tdl_checker u_tdl_checker (.*);

// ----- dv/table_driven_lexer_top_tb.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// table_driven_lexer_top_tb
// Self-checking bench for the streaming lexer: source bytes in, tokens out.
// -----------------------------------------------------------------------------
// A queue of source bytes (directed lines, random token streams, one long
// hashed name) feeds a valid/ready driver. Every accepted
// byte runs through a scanner model kept in the bench, which queues the
// tokens it should cause; the monitor checks each token the block hands over
// against the oldest queued one, field by field. Both sides idle at random,
// and the receiver holds off once for a long stretch to back up the input.
// -----------------------------------------------------------------------------
module table_driven_lexer_top_tb;

	localparam int LEN_BITS    = 16;
	localparam int LEN_CAP     = (LEN_BITS >= 16) ? 65535 : ((1 << LEN_BITS) - 1);
	localparam int RANDOM_ITEMS = 850;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 20;

	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_NAME,
		SCAN_OPRUN,
		SCAN_NUM
	} scan_t;

	typedef struct {
		logic [7:0]  ch;
		logic        comma_ok;
		int unsigned idle_phase;
	} src_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  char_byte = 8'd0;
	logic        newline_comma_ok = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [4:0]  token_kind;
	logic [2:0]  token_level;
	logic [63:0] token_value;
	logic [15:0] token_length;
	logic        is_hashed;
	logic        last_of_run;

	src_item_t      src_q[$];
	tdl_pkg::tok_t  tok_q[$];
	int unsigned item_count = 0;
	int unsigned sent_count = 0;
	int unsigned item_phase = 0;
	int unsigned hold_cnt = 0;
	bit          hold_done = 1'b0;
	int unsigned err_count = 0;
	longint unsigned cycle_count = 0;
	longint unsigned cycle_limit = 0;

	// scanner state of the model
	scan_t       sc_mode = SCAN_IDLE;
	logic [63:0] sc_packed = '0;
	logic [31:0] sc_hash = '0;
	logic [15:0] sc_count = '0;
	logic [31:0] sc_acc = '0;
	logic [2:0]  sc_prec = '0;

	table_driven_lexer_top #(
		.LENGTH_BITS(LEN_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_byte(char_byte),
		.newline_comma_ok(newline_comma_ok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.token_kind(token_kind),
		.token_level(token_level),
		.token_value(token_value),
		.token_length(token_length),
		.is_hashed(is_hashed),
		.last_of_run(last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- model
	function automatic int op_level(logic [7:0] c);
		case (c)
			"=", "|": return 0;
			"&": return 1;
			"<", ">": return 2;
			"+", "-": return 3;
			"*", "/", "\\": return 4;
			default: return -1;
		endcase
	endfunction

	function automatic int punct_of(logic [7:0] c);
		case (c)
			"{": return tdl_pkg::KIND_LBRACE;
			"}": return tdl_pkg::KIND_RBRACE;
			"(": return tdl_pkg::KIND_LPAREN;
			")": return tdl_pkg::KIND_RPAREN;
			"[": return tdl_pkg::KIND_LBRACKET;
			"]": return tdl_pkg::KIND_RBRACKET;
			":": return tdl_pkg::KIND_COLON;
			";": return tdl_pkg::KIND_SEMI;
			",": return tdl_pkg::KIND_COMMA;
			default: return -1;
		endcase
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic tdl_pkg::tok_t mk_tok(tdl_pkg::kind_t k, logic [2:0] p, logic [63:0] v,
			logic [15:0] len, logic h);
		tdl_pkg::tok_t t;
		t.kind   = k;
		t.prec   = p;
		t.value  = v;
		t.length = len;
		t.hashed = h;
		t.last   = 1'b0;
		return t;
	endfunction

	function automatic void open_name(logic [7:0] c);
		sc_packed = {55'd0, 1'b1, c};
		sc_hash   = sc_packed[31:0];
		sc_count  = 16'd1;
	endfunction

	function automatic void extend_name(logic [7:0] c);
		sc_packed = (sc_packed << 8) + {56'd0, c};
		sc_hash   = {sc_hash[14:0], sc_hash[31:15]} + sc_packed[31:0];
		if (sc_count < LEN_CAP)
			sc_count = sc_count + 16'd1;
	endfunction

	function automatic tdl_pkg::tok_t name_token(bit is_op);
		tdl_pkg::kind_t k;
		logic [2:0]     p;
		logic [31:0]    h;
		k = is_op ? tdl_pkg::KIND_OP : tdl_pkg::KIND_IDENT;
		p = is_op ? sc_prec : 3'd0;
		if (sc_count <= tdl_pkg::SHORT_NAME_MAX) begin
			if (sc_packed == tdl_pkg::KEY_BAR) begin
				k = tdl_pkg::KIND_BAR;
				p = 3'd0;
			end else if (sc_packed == tdl_pkg::KEY_EQ) begin
				k = tdl_pkg::KIND_EQ;
				p = 3'd0;
			end else if (sc_packed == tdl_pkg::KEY_LET) begin
				k = tdl_pkg::KIND_LET;
				p = 3'd0;
			end
			return mk_tok(k, p, sc_packed, sc_count, 1'b0);
		end
		h = sc_hash;
		h = h * ((h << 1) + 32'd1);
		if (h == 32'd0)
			h = 32'd1;
		return mk_tok(k, p, {32'd0, h}, sc_count, 1'b1);
	endfunction

	// Advance the scanner by one byte and queue the tokens it causes.
	task automatic scan_byte(input logic [7:0] c, input logic comma_ok);
		tdl_pkg::tok_t t [2];
		int   n;
		int   lvl;
		int   pk;
		n   = 0;
		lvl = op_level(c);
		pk  = punct_of(c);
		case (sc_mode)
			SCAN_NAME: begin
				if (is_letter(c) || is_digit(c) || c >= 8'd128) begin
					extend_name(c);
					return;
				end
				t[n] = name_token(1'b0);
				n++;
			end
			SCAN_OPRUN: begin
				if (lvl >= 0) begin
					extend_name(c);
					return;
				end
				t[n] = name_token(1'b1);
				n++;
			end
			SCAN_NUM: begin
				if (is_digit(c)) begin
					sc_acc = sc_acc * 32'd10 + {24'd0, c - 8'h30};
					return;
				end
				t[n] = mk_tok(tdl_pkg::KIND_INT, 3'd0, {32'd0, sc_acc}, 16'd0, 1'b0);
				n++;
			end
			default: ;
		endcase
		sc_mode = SCAN_IDLE;

		// the closing byte starts afresh
		if (lvl >= 0) begin
			open_name(c);
			sc_prec = lvl[2:0];
			sc_mode = SCAN_OPRUN;
		end else if (is_letter(c) || c == "'" || c == ".") begin
			open_name(c);
			sc_prec = 3'd0;
			sc_mode = SCAN_NAME;
		end else if (is_digit(c)) begin
			sc_acc  = {24'd0, c - 8'h30};
			sc_mode = SCAN_NUM;
		end else if (pk >= 0) begin
			t[n] = mk_tok(tdl_pkg::kind_t'(pk[4:0]), 3'd0, 64'd0, 16'd0, 1'b0);
			n++;
		end else if (c == 8'd0) begin
			t[n] = mk_tok(tdl_pkg::KIND_EOF, 3'd0, 64'd0, 16'd0, 1'b0);
			n++;
		end else if (c == " ") begin
		end else if (c == 8'h0D || c == 8'h0A) begin
			if (comma_ok) begin
				t[n] = mk_tok(tdl_pkg::KIND_COMMA, 3'd0, 64'd0, 16'd0, 1'b0);
				n++;
			end
		end else begin
			t[n] = mk_tok(tdl_pkg::KIND_ERR, 3'd0, 64'd0, 16'd0, 1'b0);
			n++;
		end

		for (int i = 0; i < n; i++) begin
			t[i].last = (i == n - 1);
			tok_q.insert(tok_q.size(), t[i]);
		end
	endtask

	// ------------------------------------------------------------ stimulus
	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic add_item(input logic [7:0] c, input logic ok, input int unsigned ph);
		src_item_t it;
		it.ch         = c;
		it.comma_ok   = ok;
		it.idle_phase = ph;
		src_q.insert(src_q.size(), it);
		item_count++;
	endtask

	task automatic add_str(input string s, input int unsigned ph);
		for (int i = 0; i < s.len(); i++)
			add_item(s[i], coin(), ph);
	endtask

	// One random token, mostly well formed, with some noise.
	task automatic add_random_token(input int unsigned ph);
		string letters;
		string ops;
		string puncts;
		int    sel;
		int    len;
		letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
		ops     = "=|&<>+-*/\\";
		puncts  = "{}()[]:;,";
		sel     = $urandom_range(0, 99);
		if (sel < 25) begin
			if ($urandom_range(0, 9) == 0) begin
				add_str("let", ph);
			end else begin
				case ($urandom_range(0, 5))
					0: add_item("'", coin(), ph);
					1: add_item(".", coin(), ph);
					default: add_item(letters[$urandom_range(0, 51)], coin(), ph);
				endcase
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 7);
				for (int i = 0; i < len; i++) begin
					case ($urandom_range(0, 2))
						0: add_item(letters[$urandom_range(0, 51)], coin(), ph);
						1: add_item(8'(8'h30 + $urandom_range(0, 9)), coin(), ph);
						default: add_item(8'($urandom_range(128, 255)), coin(), ph);
					endcase
				end
			end
		end else if (sel < 40) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
			for (int i = 0; i < len; i++)
				add_item(ops[$urandom_range(0, 9)], coin(), ph);
		end else if (sel < 55) begin
			len = $urandom_range(1, 13);
			for (int i = 0; i < len; i++)
				add_item(8'(8'h30 + $urandom_range(0, 9)), coin(), ph);
		end else if (sel < 68) begin
			add_item(puncts[$urandom_range(0, 8)], coin(), ph);
		end else if (sel < 80) begin
			case ($urandom_range(0, 2))
				0: add_item(" ", coin(), ph);
				1: add_item(8'h0D, coin(), ph);
				default: add_item(8'h0A, coin(), ph);
			endcase
		end else if (sel < 85) begin
			add_item(8'd0, coin(), ph);
		end else if (sel < 93) begin
			add_item(8'($urandom_range(0, 255)), coin(), ph);
		end else begin
			add_item(8'($urandom_range(128, 255)), coin(), ph);
		end
	endtask

	function automatic int unsigned sender_gap(int unsigned ph);
		case (ph)
			0: return 8;
			1: return 55;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned receiver_gap(int unsigned ph);
		case (ph)
			0: return 55;
			1: return 8;
			default: return 0;
		endcase
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		if (err_count < 100)
			$display("ERROR at %0t: %s got %0h want %0h", $realtime, what, got, want);
		err_count++;
	endtask

	// -------------------------------------------------------------- driver
	always @(posedge clk or negedge arst_n) begin : driver_proc
		src_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				scan_byte(char_byte, newline_comma_ok);
				sent_count <= sent_count + 1;
			end
			if (!in_valid || in_ready) begin
				if (src_q.size() != 0 &&
						$urandom_range(0, 99) >= sender_gap(src_q[0].idle_phase)) begin
					nxt = src_q.pop_front();
					char_byte        <= nxt.ch;
					newline_comma_ok <= nxt.comma_ok;
					item_phase       <= nxt.idle_phase;
					in_valid         <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Hold the receiver off once, long enough to fill the token queue.
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (!hold_done && sent_count >= 200) begin
			hold_cnt  <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// ------------------------------------------------------------- monitor
	always @(posedge clk or negedge arst_n) begin : monitor_proc
		tdl_pkg::tok_t want_tok;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (tok_q.size() == 0) begin
					report("unexpected token, kind", {59'd0, token_kind}, 64'd0);
				end else begin
					want_tok = tok_q.pop_front();
					if (token_kind !== want_tok.kind)
						report("token_kind", {59'd0, token_kind}, {59'd0, want_tok.kind});
					if (token_level !== want_tok.prec)
						report("token_level", {61'd0, token_level}, {61'd0, want_tok.prec});
					if (token_value !== want_tok.value)
						report("token_value", token_value, want_tok.value);
					if (token_length !== want_tok.length)
						report("token_length", {48'd0, token_length}, {48'd0, want_tok.length});
					if (is_hashed !== want_tok.hashed)
						report("is_hashed", {63'd0, is_hashed}, {63'd0, want_tok.hashed});
					if (last_of_run !== want_tok.last)
						report("last_of_run", {63'd0, last_of_run}, {63'd0, want_tok.last});
				end
			end
			out_ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= receiver_gap(item_phase));
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_limit != 0 && cycle_count > cycle_limit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// -------------------------------------------------------------- sequence
	initial begin
		// keywords, two tokens from one byte, high byte at token start
		add_str("let |[=7]", 0);
		add_item(8'h80, 1'b1, 0);
		add_str(".q", 0);
		add_item(8'hFF, 1'b1, 0);
		add_str("9{}():;,&\\#", 0);
		// newlines with and without a comma, then end of file
		add_item(8'h0D, 1'b1, 0);
		add_item(8'h0A, 1'b0, 0);
		add_item(8'd0, 1'b0, 0);

		for (int ph = 0; ph < 3; ph++) begin
			while (item_count < 30 + RANDOM_ITEMS * (ph + 1) / 3)
				add_random_token(ph);
		end

		// long name that comes out hashed
		add_item(".", 1'b0, 2);
		for (int i = 0; i < 24; i++)
			add_item("z", 1'b0, 2);
		add_item(" ", 1'b0, 2);
		add_item(8'd0, 1'b0, 2);

		cycle_limit = 40 * longint'(item_count) + 50000;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (src_q.size() != 0 || in_valid)
			@(posedge clk);
		while (tok_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tok_q.size() != 0)
			report("tokens never delivered", 64'(tok_q.size()), 64'd0);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
